[sv/nfba_pkg.sv]
package nfba_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int INDEX_SPAN     = 1024;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int WORD_W  = 64;
  localparam int LOG_W   = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(1024);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_BLOCK_COUNT = 1'b0;

endpackage

[sv/nfba_ram.sv]
module nfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/next_fit_block_bitmap_allocator.sv]
// Next-fit block allocator. The usage map (one bit per block, all free after
// reset) lives in a RAM of 64-bit words; each row has a valid flop cleared by
// reset, so an unwritten row reads as free and no clearing pass is needed.
// An allocate request scans circularly from start_hint, one map word per
// cycle, up to the last active word and then from word zero back to the
// start word. A new request is taken only when the last one is done. A
// request reads one map word for a release or a hit in the start word,
// up to (active words + 1), i.e. 17 reads for 1024 blocks; out-of-range
// requests read no map word and go straight to the result. The
// single RAM read port, one word per cycle, sets the scan rate. A finished
// result waits in the output register while the next request is taken.
// block_count sits at APB address 0; the active count is block_count capped
// at min(MAX_BLOCKS, 1024).
module next_fit_block_bitmap_allocator #(
  parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nfba_pkg::PADDR_W-1:0]      paddr,
  input  logic [nfba_pkg::PDATA_W-1:0]      pwdata,
  output logic [nfba_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] start_hint, [19:10] block_index, [23:20] zero
  input  logic [nfba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] command
  input  logic                              s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] allocated_index, [15:10] zero
  output logic [nfba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] success
  output logic                              m_axis_tuser
);

  localparam int IDX_W  = nfba_pkg::IDX_W;
  localparam int CNT_W  = nfba_pkg::CNT_W;
  localparam int WORD_W = nfba_pkg::WORD_W;
  localparam int LOG_W  = nfba_pkg::LOG_W;

  localparam int MAP_BITS = (MAX_BLOCKS < nfba_pkg::INDEX_SPAN) ? MAX_BLOCKS
                                                                : nfba_pkg::INDEX_SPAN;
  localparam int DEPTH = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] MAP_BITS_C = CNT_W'(MAP_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     word_q, word_d;
  logic              pass_q, pass_d;
  logic              cmd_q, cmd_d;
  logic [IDX_W-1:0]  hint_q, hint_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              res_ok_q, res_ok_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DEPTH-1:0]  row_vld_q, row_vld_d;

  logic              accept, out_load, cfg_wr;
  logic [CNT_W-1:0]  n_act, pos_base, last_pos;
  logic [IDX_W-1:0]  in_hint, in_idx;
  logic [WORD_W-1:0] rdata, cur_word, allowed, free_bits, lowest, wdata;
  logic [LOG_W-1:0]  hit_off;
  logic              hit, at_last, at_start, ram_we;

  assign n_act    = (count_q > MAP_BITS_C) ? MAP_BITS_C : count_q;
  assign in_hint  = s_axis_tdata[IDX_W-1:0];
  assign in_idx   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == nfba_pkg::REG_BLOCK_COUNT);

  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      count_d = pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      nfba_pkg::REG_BLOCK_COUNT: prdata = nfba_pkg::PDATA_W'(count_q);
      default:                   prdata = '0;
    endcase
  end

  // word evaluation
  assign cur_word = row_vld_q[word_q] ? rdata : '0;
  assign pos_base = CNT_W'(word_q) << LOG_W;
  assign last_pos = n_act - CNT_W'(1);
  assign at_last  = (pos_base >> LOG_W) == (last_pos >> LOG_W);
  assign at_start = (pos_base >> LOG_W) == (CNT_W'(hint_q) >> LOG_W);

  always_comb begin
    logic [CNT_W-1:0] pos;
    for (int b = 0; b < WORD_W; b++) begin
      pos = pos_base + CNT_W'(b);
      allowed[b] = (pos < n_act) && (pass_q || (pos >= CNT_W'(hint_q)));
    end
  end

  assign free_bits = ~cur_word & allowed;
  assign lowest    = free_bits & (~free_bits + WORD_W'(1));
  assign hit       = |free_bits;

  always_comb begin
    hit_off = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (lowest[b]) begin
        hit_off = hit_off | LOG_W'(b);
      end
    end
  end

  // control
  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    pass_d    = pass_q;
    cmd_d     = cmd_q;
    hint_d    = hint_q;
    idx_d     = idx_q;
    res_ok_d  = res_ok_q;
    res_idx_d = res_idx_q;
    ram_we    = 1'b0;
    wdata     = cur_word;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = s_axis_tuser;
          hint_d    = in_hint;
          idx_d     = in_idx;
          pass_d    = 1'b0;
          res_ok_d  = 1'b0;
          res_idx_d = '0;
          if (s_axis_tuser == nfba_pkg::CMD_ALLOC) begin
            if (CNT_W'(in_hint) >= n_act) begin
              state_d = ST_DONE;
            end else begin
              word_d  = AW'(in_hint >> LOG_W);
              state_d = ST_SCAN;
            end
          end else begin
            if (CNT_W'(in_idx) >= n_act) begin
              state_d = ST_DONE;
            end else begin
              word_d  = AW'(in_idx >> LOG_W);
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cmd_q == nfba_pkg::CMD_RELEASE) begin
          ram_we   = 1'b1;
          wdata    = cur_word & ~(WORD_W'(1) << idx_q[LOG_W-1:0]);
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end else if (hit) begin
          ram_we    = 1'b1;
          wdata     = cur_word | lowest;
          res_ok_d  = 1'b1;
          res_idx_d = IDX_W'(pos_base) | IDX_W'(hit_off);
          state_d   = ST_DONE;
        end else if (pass_q && at_start) begin
          state_d = ST_DONE;
        end else if (!pass_q && at_last) begin
          word_d = '0;
          pass_d = 1'b1;
        end else begin
          word_d = word_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_comb begin
    row_vld_d = row_vld_q;
    if (ram_we) begin
      row_vld_d[word_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= nfba_pkg::BLOCK_COUNT_RST;
      row_vld_q   <= '0;
      word_q      <= '0;
      pass_q      <= 1'b0;
      cmd_q       <= nfba_pkg::CMD_ALLOC;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      row_vld_q   <= row_vld_d;
      word_q      <= word_d;
      pass_q      <= pass_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hint_q    <= hint_d;
    idx_q     <= idx_d;
    res_ok_q  <= res_ok_d;
    res_idx_q <= res_idx_d;
    if (out_load) begin
      out_ok_q  <= res_ok_q;
      out_idx_q <= res_idx_q;
    end
  end

  nfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (wdata),
    .raddr_i (word_d),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = nfba_pkg::OUT_TDATA_W'(out_idx_q);
  assign m_axis_tuser  = out_ok_q;

endmodule
